// ===== hdl/dhglcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dhglcd_pkg;

    localparam int unsigned CFG_W      = 10;
    localparam int unsigned BUSY_WIDTH = 10;
    localparam int unsigned SAT_W      = CFG_W + BUSY_WIDTH;

    localparam logic [SAT_W-1:0] BUSY_MAX = SAT_W'((64'd1 << BUSY_WIDTH) - 64'd1);
    localparam logic [CFG_W-1:0] BUSY_TICKS_RESET = CFG_W'(50);

    localparam int unsigned RAM_DEPTH = 1024;
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

    localparam logic [2:0] CMD_BUS    = 3'd0;
    localparam logic [2:0] CMD_RST_LO = 3'd1;
    localparam logic [2:0] CMD_RST_HI = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_FETCH  = 3'd4;

    localparam logic [7:0] INS_ONOFF_MASK = 8'hFE;
    localparam logic [7:0] INS_ONOFF      = 8'h3E;
    localparam logic [7:0] INS_COL_MASK   = 8'hC0;
    localparam logic [7:0] INS_COL        = 8'h40;
    localparam logic [7:0] INS_PAGE_MASK  = 8'hF8;
    localparam logic [7:0] INS_PAGE       = 8'hB8;
    localparam logic [7:0] INS_LINE_MASK  = 8'hC0;
    localparam logic [7:0] INS_LINE       = 8'hC0;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [RAM_AW-1:0] raddr;
    } t_ram_req;

    function automatic logic [BUSY_WIDTH-1:0] sat_busy(input logic [CFG_W-1:0] ticks);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(ticks);
        if (wide > BUSY_MAX) begin
            wide = BUSY_MAX;
        end
        return wide[BUSY_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dual_half_graphic_lcd_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-half 128x64 graphic LCD controller. Each input beat is one bus access,
// reset-pin change, time tick or display fetch and yields exactly one result
// beat. An item passes through an execute state that reads or writes the
// 1024x8 display RAM, then a response state that takes the registered RAM
// data, updates the per-half registers and loads the output register once the
// output slot is free; the next item is accepted as that response completes.
// A data write to both halves writes the left half in the execute state and
// the right half in the response state. After block reset a clearing pass
// zeroes all 1024 display RAM locations with the input not ready. The
// busy_ticks port is always ready; a write applies to items completing later.

module dual_half_graphic_lcd_controller_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_command,
    input  wire         i_rs,
    input  wire         i_rw,
    input  wire         i_cs1_n,
    input  wire         i_cs2_n,
    input  wire  [7:0]  i_data_in,
    input  wire  [2:0]  i_fetch_page,
    input  wire  [6:0]  i_fetch_column,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_bus_data,
    output logic        o_bus_driven,
    output logic        o_busy_rejected,
    output logic [7:0]  o_fetch_data,
    output logic        o_half_on,
    output logic [5:0]  o_half_start_line,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [dhglcd_pkg::CFG_W-1:0]      i_cfg_busy_ticks
);
    import dhglcd_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [RAM_AW-1:0] r_clr_addr;
    logic [CFG_W-1:0]  r_busy_ticks;

    logic [2:0] r_cmd;
    logic       r_rs, r_rw;
    logic [1:0] r_sel;
    logic [7:0] r_din;
    logic [2:0] r_fp;
    logic [6:0] r_fc;

    logic [5:0]            r_col   [2];
    logic [2:0]            r_page  [2];
    logic [5:0]            r_start [2];
    logic                  r_on    [2];
    logic [7:0]            r_latch [2];
    logic [BUSY_WIDTH-1:0] r_busy  [2];
    logic                  r_in_reset;

    logic r_out_valid;

    t_ram_req   ram_req;
    logic [7:0] ram_q;

    logic is_bus, any_sel, status_rd, busy_hit, go, rejected, driven;
    logic h_st, h_rd, h_fc;
    logic data_wr, data_rd, ins_wr, slot_free, complete, accept;
    logic [7:0] status_byte, bus_byte;
    logic [BUSY_WIDTH-1:0] busy_load;

    dhglcd_ram u_ram (
        .i_clk (i_clk),
        .i_req (ram_req),
        .o_q   (ram_q)
    );

    always_comb begin
        is_bus    = (r_cmd == CMD_BUS);
        any_sel   = r_sel[0] | r_sel[1];
        status_rd = r_rw & ~r_rs;
        h_st      = ~r_sel[0];
        h_rd      = r_sel[1];
        h_fc      = r_fc[6];
        busy_hit  = (r_sel[0] && (r_busy[0] != '0)) || (r_sel[1] && (r_busy[1] != '0));
        go        = is_bus && !status_rd && any_sel && !r_in_reset && !busy_hit;
        rejected  = is_bus && !status_rd && any_sel && !r_in_reset && busy_hit;
        driven    = is_bus && any_sel && r_rw;
        data_wr   = go && r_rs && !r_rw;
        data_rd   = go && r_rs && r_rw;
        ins_wr    = go && !r_rs && !r_rw;
        status_byte = {(r_busy[h_st] != '0), 1'b0, r_on[h_st], r_in_reset, 4'b0000};
        bus_byte  = !driven ? 8'h00 : (status_rd ? status_byte : r_latch[h_rd]);
        busy_load = sat_busy(r_busy_ticks);
        slot_free = !r_out_valid || i_out_ready;
        complete  = (r_state == ST_RESP) && slot_free;
        accept    = i_in_valid && o_in_ready;
    end

    assign o_in_ready  = (r_state == ST_IDLE) || complete;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_comb begin
        ram_req = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_clr_addr;
            end
            ST_EXEC: begin
                if (data_wr && r_sel[0]) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = {1'b0, r_page[0], r_col[0]};
                    ram_req.wdata = r_din;
                end
                if (data_rd) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = {h_rd, r_page[h_rd], r_col[h_rd]};
                end
                if (r_cmd == CMD_FETCH) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = {h_fc, r_fp, r_fc[5:0]};
                end
            end
            ST_RESP: begin
                if (data_wr && r_sel[1]) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = {1'b1, r_page[1], r_col[1]};
                    ram_req.wdata = r_din;
                end
            end
            default: begin
                ram_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == RAM_AW'(RAM_DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_RESP;
            ST_RESP: begin
                if (complete) begin
                    n_state = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_busy_ticks <= BUSY_TICKS_RESET;
            r_out_valid  <= 1'b0;
            r_in_reset   <= 1'b0;
            for (int h = 0; h < 2; h++) begin
                r_col[h]   <= '0;
                r_page[h]  <= '0;
                r_start[h] <= '0;
                r_on[h]    <= 1'b0;
                r_latch[h] <= '0;
                r_busy[h]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + RAM_AW'(1);
            end
            if (i_cfg_valid) begin
                r_busy_ticks <= i_cfg_busy_ticks;
            end
            if (complete) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (complete) begin
                if (go) begin
                    for (int h = 0; h < 2; h++) begin
                        if (r_sel[h]) r_busy[h] <= busy_load;
                    end
                end
                if (data_wr) begin
                    for (int h = 0; h < 2; h++) begin
                        if (r_sel[h]) r_col[h] <= r_col[h] + 6'd1;
                    end
                end
                if (data_rd) begin
                    r_latch[h_rd] <= ram_q;
                    r_col[h_rd]   <= r_col[h_rd] + 6'd1;
                end
                if (ins_wr) begin
                    for (int h = 0; h < 2; h++) begin
                        if (r_sel[h]) begin
                            if ((r_din & INS_ONOFF_MASK) == INS_ONOFF) r_on[h] <= r_din[0];
                            if ((r_din & INS_COL_MASK) == INS_COL) r_col[h] <= r_din[5:0];
                            if ((r_din & INS_PAGE_MASK) == INS_PAGE) r_page[h] <= r_din[2:0];
                            if ((r_din & INS_LINE_MASK) == INS_LINE) r_start[h] <= r_din[5:0];
                        end
                    end
                end
                case (r_cmd)
                    CMD_RST_LO: begin
                        r_in_reset <= 1'b1;
                        for (int h = 0; h < 2; h++) begin
                            r_on[h]    <= 1'b0;
                            r_start[h] <= '0;
                        end
                    end
                    CMD_RST_HI: r_in_reset <= 1'b0;
                    CMD_TICK: begin
                        for (int h = 0; h < 2; h++) begin
                            if (r_busy[h] != '0) r_busy[h] <= r_busy[h] - BUSY_WIDTH'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_rs  <= i_rs;
            r_rw  <= i_rw;
            r_sel <= {~i_cs2_n, ~i_cs1_n};
            r_din <= i_data_in;
            r_fp  <= i_fetch_page;
            r_fc  <= i_fetch_column;
        end
        if (complete) begin
            o_bus_data      <= bus_byte;
            o_bus_driven    <= driven;
            o_busy_rejected <= rejected;
            if (r_cmd == CMD_FETCH) begin
                o_fetch_data      <= ram_q;
                o_half_on         <= r_on[h_fc];
                o_half_start_line <= r_start[h_fc];
            end else begin
                o_fetch_data      <= '0;
                o_half_on         <= 1'b0;
                o_half_start_line <= '0;
            end
        end
    end

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready)
        else $error("input ready during RAM clearing pass");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted beat did not enter execute");

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.we && ram_req.re))
        else $error("RAM read and write in the same cycle");

    a_reject_holds_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (complete && rejected) |=> ($stable(r_busy[0]) && $stable(r_busy[1])))
        else $error("rejected access changed busy counters");

    a_result_after_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        complete |=> r_out_valid)
        else $error("completed item produced no result beat");

endmodule

`default_nettype wire

// ===== hdl/dhglcd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dhglcd_ram (
    input  wire                    i_clk,
    input  dhglcd_pkg::t_ram_req   i_req,
    output logic [7:0]             o_q
);
    import dhglcd_pkg::*;

    logic [7:0] mem [RAM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_q <= mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire
